FILE: rtl/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
// Used by fpba_mem, fpba_scan and fit_policy_block_allocator; no dependencies.
package fpba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int INDEX_W    = 4;
	localparam int AMOUNT_W   = 16;
	localparam int MODE_W     = 2;
	localparam int BCOUNT_W   = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} fpba_state_t;

	typedef struct packed {
		logic [MODE_W-1:0]   fit_mode;
		logic [BCOUNT_W-1:0] block_count;
	} fpba_cfg_t;

	typedef struct packed {
		logic                granted;
		logic [INDEX_W-1:0]  chosen_block;
		logic [AMOUNT_W-1:0] space_left;
	} fpba_res_t;

endpackage

FILE: rtl/fpba_mem.sv
// Free-space table: one write port, one read port with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses fpba_pkg.
module fpba_mem #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [$clog2(NUM_BLOCKS)-1:0] waddr,
	input  logic [SIZE_BITS-1:0]          wdata,
	input  logic                          re,
	input  logic [$clog2(NUM_BLOCKS)-1:0] raddr,
	output logic [SIZE_BITS-1:0]          rdata
);
	import fpba_pkg::*;

	logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] vld_q;
	logic [SIZE_BITS-1:0]  rd_data_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
			rd_vld_q  <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: rtl/fpba_scan.sv
// Request sequencer: applies loads, scans the table one entry per cycle,
// keeps the running pick and writes the winner back. Uses fpba_pkg and fpba_mem.
module fpba_scan #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpba_pkg::fpba_cfg_t                 cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_action,
	input  logic [fpba_pkg::INDEX_W-1:0]        in_load_index,
	input  logic [fpba_pkg::AMOUNT_W-1:0]       in_amount,
	output logic                                res_valid,
	input  logic                                res_ready,
	output fpba_pkg::fpba_res_t                 res
);
	import fpba_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int LW    = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
	localparam int LIW   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam int CW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

	fpba_state_t state_q, state_d;

	logic [MODE_W-1:0]    mode_q;
	logic [CNT_W-1:0]     limit_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [AMOUNT_W-1:0]  amt_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_val_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic                 accept;
	logic                 load_ok;
	logic [LW-1:0]        bc_ext;
	logic [CNT_W-1:0]     limit;
	logic                 last_rd;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [SIZE_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [SIZE_BITS-1:0] mem_rdata;
	logic [SIZE_BITS-1:0] new_val;
	logic                 fits;
	logic                 better;
	logic                 take;

	fpba_mem #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	assign accept  = in_valid && in_ready;
	assign load_ok = LIW'(in_load_index) < LIW'(NUM_BLOCKS);
	assign bc_ext  = LW'(cfg.block_count);
	assign limit   = (bc_ext > LW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bc_ext);
	assign last_rd = (cnt_q + CNT_W'(1)) == limit_q;
	assign new_val = best_val_q - SIZE_BITS'(amt_q);

	assign fits = CW'(mem_rdata) >= CW'(amt_q);
	always_comb begin
		unique case (mode_q)
			MODE_BEST:  better = mem_rdata < best_val_q;
			MODE_WORST: better = mem_rdata > best_val_q;
			default:    better = 1'b0;
		endcase
	end
	assign take = rd_vld_s1 && fits && (!found_q || better);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = IDX_W'(in_load_index);
		mem_wdata = SIZE_BITS'(in_amount);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == ACT_LOAD) begin
						mem_we = load_ok;
					end else if (limit == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				mem_re = 1'b1;
				if (last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				res_valid = 1'b1;
				mem_waddr = best_idx_q;
				mem_wdata = new_val;
				if (res_ready) begin
					mem_we  = found_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		res.granted      = found_q;
		res.chosen_block = found_q ? INDEX_W'(best_idx_q) : '0;
		res.space_left   = found_q ? AMOUNT_W'(new_val) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			found_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			if (accept) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= cfg.fit_mode;
			limit_q <= limit;
			amt_q   <= in_amount;
			cnt_q   <= '0;
		end else if (mem_re) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (take) begin
			best_idx_q <= idx_s1;
			best_val_q <= mem_rdata;
		end
	end

endmodule

FILE: rtl/fit_policy_block_allocator.sv
// Fit-policy block allocator, top level. A load writes one table entry and gives no result.
// A request scans block_count entries (block_count capped at NUM_BLOCKS, no scan when
// it is zero): the scan reads one table entry per cycle through the single memory read port,
// then writes back. One item is in flight at a time; the output register lets the next item
// start while a result waits. Reset clears the table to zero, fit_mode to first fit,
// block_count to 16.
module fit_policy_block_allocator #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [23:0]                        s_tdata,  // load_index[3:0], amount[19:4]
	input  logic                               s_tuser,  // action
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,  // chosen_block[3:0], space_left[19:4]
	output logic                               m_tuser   // granted
);
	import fpba_pkg::*;

	fpba_cfg_t cfg_q;
	fpba_res_t res;
	fpba_res_t out_res_q;
	logic      out_vld_q;
	logic      res_valid;
	logic      res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fit_mode    <= MODE_FIRST;
			cfg_q.block_count <= BLOCK_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FIT_MODE:    cfg_q.fit_mode    <= cfg_data[MODE_W-1:0];
				CFG_BLOCK_COUNT: cfg_q.block_count <= cfg_data[BCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	fpba_scan #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_action    (s_tuser),
		.in_load_index(s_tdata[3:0]),
		.in_amount    (s_tdata[19:4]),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_res_q.granted;
	assign m_tdata  = {4'd0, out_res_q.space_left, out_res_q.chosen_block};

	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 24'd0)
		else $error("refused request carries nonzero data");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_REQUEST |=> !s_tready)
		else $error("request accepted without leaving idle");

	a_res_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_tready)
		else $error("result offered while input side is open");

endmodule

FILE: sim/fit_policy_block_allocator_tb.sv
// Testbench for fit_policy_block_allocator: drives load and request beats plus register
// writes, predicts each grant in a scoreboard class and checks every result beat.
// Depends on fpba_pkg and the fit_policy_block_allocator RTL.
`timescale 1ns / 1ps

module fit_policy_block_allocator_tb;
	import fpba_pkg::*;

	localparam int            TABLE_DEPTH  = NUM_BLOCKS_DEF;
	localparam int            DRAIN_CYCLES = NUM_BLOCKS_DEF + 8;
	localparam longint        CYCLE_LIMIT  = 1500000;
	localparam int            PHASES       = 12;
	localparam int            PHASE_ITEMS  = 163;
	localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	class alloc_scoreboard;
		logic [AMOUNT_W-1:0] space_tbl[TABLE_DEPTH];
		logic [MODE_W-1:0]   mode;
		logic [BCOUNT_W-1:0] count;
		fpba_res_t           grant_q[$];
		int                  errors;

		function new();
			foreach (space_tbl[i])
				space_tbl[i] = '0;
			mode   = MODE_FIRST;
			count  = BLOCK_COUNT_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_FIT_MODE)
				mode = val[MODE_W-1:0];
			else if (idx == CFG_BLOCK_COUNT)
				count = val[BCOUNT_W-1:0];
		endfunction

		function void note_item(logic act, logic [INDEX_W-1:0] idx, logic [AMOUNT_W-1:0] amt);
			int        lim;
			bit        found;
			int        pick;
			fpba_res_t res;
			if (act == ACT_LOAD) begin
				space_tbl[idx] = amt;
				return;
			end
			lim   = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
			found = 0;
			pick  = 0;
			for (int j = 0; j < lim; j++) begin
				if (space_tbl[j] < amt)
					continue;
				if (!found) begin
					found = 1;
					pick  = j;
					if (mode != MODE_BEST && mode != MODE_WORST)
						break;
				end else if (mode == MODE_BEST) begin
					if (space_tbl[j] < space_tbl[pick])
						pick = j;
				end else if (mode == MODE_WORST) begin
					if (space_tbl[j] > space_tbl[pick])
						pick = j;
				end
			end
			res = '0;
			if (found) begin
				space_tbl[pick]  = space_tbl[pick] - amt;
				res.granted      = 1'b1;
				res.chosen_block = pick[INDEX_W-1:0];
				res.space_left   = space_tbl[pick];
			end
			grant_q.push_back(res);
		endfunction

		function void check_result(fpba_res_t got);
			fpba_res_t exp_res;
			if (grant_q.size() == 0) begin
				$error("unexpected result beat: granted=%0d chosen_block=%0d space_left=%0d",
					got.granted, got.chosen_block, got.space_left);
				errors++;
				return;
			end
			exp_res = grant_q.pop_front();
			if (got.granted !== exp_res.granted) begin
				$error("granted: expected %0d, got %0d", exp_res.granted, got.granted);
				errors++;
			end
			if (got.chosen_block !== exp_res.chosen_block) begin
				$error("chosen_block: expected %0d, got %0d",
					exp_res.chosen_block, got.chosen_block);
				errors++;
			end
			if (got.space_left !== exp_res.space_left) begin
				$error("space_left: expected %0d, got %0d", exp_res.space_left, got.space_left);
				errors++;
			end
		endfunction

		function int pending();
			return grant_q.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;  // load_index[3:0], amount[19:4]
	logic                  s_tuser   = 1'b0;  // action
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [23:0]           m_tdata;  // chosen_block[3:0], space_left[19:4]
	logic                  m_tuser;  // granted

	alloc_scoreboard sb = new();
	bit              quiet = 1'b0;
	int              stall_left = 0;
	longint          cycles = 0;

	fit_policy_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin : pick_ready
			int g;
			g = pick_gap();
			stall_left <= (g > 0) ? g - 1 : 0;
			m_tready   <= (g == 0);
		end
	end

	always @(posedge clk) begin : result_monitor
		fpba_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.granted      = m_tuser;
			got.chosen_block = m_tdata[3:0];
			got.space_left   = m_tdata[19:4];
			sb.check_result(got);
		end
	end

	task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
			input logic [AMOUNT_W-1:0] amt);
		int gap;
		gap = pick_gap();
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, amt, idx};
		do @(posedge clk); while (!s_tready);
		sb.note_item(act, idx, amt);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// hold off until no grant is outstanding and any trailing load has landed
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [BCOUNT_W-1:0] cnt);
		wait_idle();
		write_reg(CFG_FIT_MODE, {3'($urandom_range(0, 7)), mode});
		write_reg(CFG_BLOCK_COUNT, cnt);
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
				5'($urandom_range(0, 31)));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int   r;
		logic act;
		logic [INDEX_W-1:0]  idx;
		logic [AMOUNT_W-1:0] amt;
		r   = $urandom_range(0, 99);
		idx = 4'($urandom_range(0, 15));
		if (r < 10) begin
			act = 1'($urandom_range(0, 1));
			amt = 16'($urandom_range(0, 65535));
		end else if (r < 50) begin
			act = ACT_LOAD;
			r   = $urandom_range(0, 99);
			if (r < 40)
				amt = 16'($urandom_range(0, 255));
			else if (r < 65)
				amt = 16'(16 * $urandom_range(1, 4));
			else if (r < 85)
				amt = 16'($urandom_range(256, 4095));
			else
				amt = 16'($urandom_range(0, 65535));
		end else begin
			act = ACT_REQUEST;
			r   = $urandom_range(0, 99);
			if (r < 10)
				amt = '0;
			else if (r < 70)
				amt = 16'($urandom_range(1, 64));
			else if (r < 92)
				amt = 16'($urandom_range(65, 2048));
			else
				amt = 16'($urandom_range(0, 65535));
		end
		send_item(act, idx, amt);
	endtask

	initial begin
		logic [MODE_W-1:0]   phase_mode[PHASES];
		logic [BCOUNT_W-1:0] phase_count[PHASES];
		phase_mode  = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE, MODE_BEST, MODE_WORST,
			MODE_FIRST, MODE_BEST, MODE_WORST, MODE_FIRST, MODE_BEST, MODE_WORST};
		phase_count = '{5'd16, 5'd16, 5'd16, 5'd16, 5'd1, 5'd31, 5'd5, 5'd8, 5'd17,
			5'd16, 5'd16, 5'd16};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cleared table, default first fit over all blocks
		send_item(ACT_REQUEST, 4'd0, 16'd0);
		send_item(ACT_REQUEST, 4'd0, 16'd1);
		send_item(ACT_LOAD, 4'd15, 16'hFFFF);
		send_item(ACT_LOAD, 4'd7, 16'h8000);
		send_item(ACT_LOAD, 4'd3, 16'h8000);
		send_item(ACT_REQUEST, 4'd0, 16'hFFFF);
		send_item(ACT_REQUEST, 4'd0, 16'h8000);
		send_item(ACT_REQUEST, 4'd0, 16'hFFFF);
		send_item(ACT_LOAD, 4'd1, 16'd100);
		send_item(ACT_LOAD, 4'd2, 16'd50);
		send_item(ACT_LOAD, 4'd4, 16'd50);

		set_policy(MODE_BEST, 5'd16);
		send_item(ACT_REQUEST, 4'd0, 16'd40);
		send_item(ACT_REQUEST, 4'd0, 16'd10);

		set_policy(MODE_WORST, 5'd16);
		send_item(ACT_REQUEST, 4'd0, 16'd10);
		send_item(ACT_REQUEST, 4'd0, 16'd0);

		set_policy(MODE_SPARE, 5'd16);
		send_item(ACT_REQUEST, 4'd0, 16'd20);

		set_policy(MODE_FIRST, 5'd0);
		send_item(ACT_REQUEST, 4'd0, 16'd0);

		set_policy(MODE_BEST, 5'd31);
		send_item(ACT_REQUEST, 4'd0, 16'd50);

		set_policy(MODE_WORST, 5'd1);
		send_item(ACT_LOAD, 4'd0, 16'd9);
		send_item(ACT_REQUEST, 4'd0, 16'd9);
		send_item(ACT_REQUEST, 4'd0, 16'd1);

		for (int p = 0; p < PHASES; p++) begin
			if (p >= 9)
				set_policy(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
			else
				set_policy(phase_mode[p], phase_count[p]);
			quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_item();
		end

		quiet = 1'b0;
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/fpba_pkg.sv
rtl/fpba_mem.sv
rtl/fpba_scan.sv
rtl/fit_policy_block_allocator.sv
sim/fit_policy_block_allocator_tb.sv
